FILE: rtl/core/min_heap_priority_queue_assert.svh
// Assertion macros for the heap priority queue RTL.
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error("mhpq: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error("mhpq: next-cycle property failed");

`endif

FILE: rtl/core/mhpq_pkg.sv
// Shared opcodes, status codes and sequencer states of the heap priority queue.
package mhpq_pkg;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// S_DONE_CODE is a finished transaction waiting for the output register.
	typedef enum logic [7:0] {
		S_IDLE      = 8'b00000001,
		S_UP_RD     = 8'b00000010,
		S_UP_CMP    = 8'b00000100,
		S_FETCH     = 8'b00001000,
		S_TAKE      = 8'b00010000,
		S_DN_RD     = 8'b00100000,
		S_DN_CMP    = 8'b01000000,
		S_DONE_CODE = 8'b10000000
	} seq_state_t;

endpackage

FILE: rtl/core/mhpq_if.sv
// Command and response channel interfaces of the heap priority queue.
interface mhpq_cmd_if #(
	parameter int KEY_WIDTH = 32
) ();
	logic                        valid;
	logic                        ready;
	logic [1:0]                  opcode;
	logic signed [KEY_WIDTH-1:0] key_in;

	modport source (output valid, output opcode, output key_in, input ready);
	modport sink (input valid, input opcode, input key_in, output ready);
endinterface

interface mhpq_rsp_if #(
	parameter int KEY_WIDTH = 32,
	parameter int CNT_W     = 7
) ();
	logic                        valid;
	logic                        ready;
	logic signed [KEY_WIDTH-1:0] key_out;
	logic [1:0]                  status;
	logic [CNT_W-1:0]            entry_count;

	modport source (output valid, output key_out, output status, output entry_count,
		input ready);
	modport sink (input valid, input key_out, input status, input entry_count,
		output ready);
endinterface

FILE: rtl/core/mhpq_mem.sv
// Key store: one write port and two registered read ports.
module mhpq_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] store [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= store[raddr_a];
		rdata_b <= store[raddr_b];
	end

endmodule

FILE: rtl/core/mhpq_ctrl.sv
// Sequencer that runs push, pop and peek against the key store.
module mhpq_ctrl #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  logic [1:0]                          cmd_opcode,
	input  logic signed [KEY_WIDTH-1:0]         cmd_key,
	output logic                                res_valid,
	input  logic                                res_take,
	output logic signed [KEY_WIDTH-1:0]         res_key,
	output mhpq_pkg::status_t                   res_status,
	output logic [$clog2(CAPACITY+1)-1:0]       res_count,
	output logic                                mem_we,
	output logic [$clog2(CAPACITY)-1:0]         mem_waddr,
	output logic signed [KEY_WIDTH-1:0]         mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]         mem_raddr_a,
	output logic [$clog2(CAPACITY)-1:0]         mem_raddr_b,
	input  logic signed [KEY_WIDTH-1:0]         mem_rdata_a,
	input  logic signed [KEY_WIDTH-1:0]         mem_rdata_b
);
	import mhpq_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = CNT_W + 1;

	seq_state_t                  state_q, state_d;
	logic [ADDR_W-1:0]           idx_q, idx_d;
	logic [CNT_W-1:0]            count_q, count_d;
	logic signed [KEY_WIDTH-1:0] hold_q, hold_d;
	logic signed [KEY_WIDTH-1:0] key_q, key_d;
	status_t                     status_q, status_d;
	logic                        is_pop_q, is_pop_d;

	logic [ADDR_W-1:0]           parent;
	logic [IDX_W-1:0]            lc, rc;
	logic                        lc_ok, rc_ok, take_l, take_r;
	logic signed [KEY_WIDTH-1:0] min_l;

	assign parent = ADDR_W'((idx_q - 1'b1) >> 1);
	assign lc     = IDX_W'({idx_q, 1'b1});
	assign rc     = lc + 1'b1;
	assign lc_ok  = lc < IDX_W'(count_q);
	assign rc_ok  = rc < IDX_W'(count_q);
	assign take_l = lc_ok && (mem_rdata_a < hold_q);
	assign min_l  = take_l ? mem_rdata_a : hold_q;
	assign take_r = rc_ok && (mem_rdata_b < min_l);

	assign cmd_ready  = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE_CODE);
	assign res_key    = key_q;
	assign res_status = status_q;
	assign res_count  = count_q;
	assign mem_waddr  = idx_q;

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		count_d     = count_q;
		hold_d      = hold_q;
		key_d       = key_q;
		status_d    = status_q;
		is_pop_d    = is_pop_q;
		mem_we      = 1'b0;
		mem_wdata   = hold_q;
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					key_d    = '0;
					status_d = ST_OK;
					state_d  = S_DONE_CODE;
					unique case (cmd_opcode)
						OP_PUSH: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_d = ST_FULL;
							end else begin
								hold_d  = cmd_key;
								idx_d   = ADDR_W'(count_q);
								count_d = count_q + 1'b1;
								state_d = S_UP_RD;
							end
						end
						OP_POP, OP_PEEK: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								is_pop_d = (cmd_opcode == OP_POP);
								state_d  = S_FETCH;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			S_UP_RD: begin
				mem_raddr_a = parent;
				if (idx_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_DONE_CODE;
				end else begin
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (mem_rdata_a <= hold_q) begin
					state_d = S_DONE_CODE;
				end else begin
					// The parent moves down into the hole and the hole climbs.
					mem_wdata = mem_rdata_a;
					idx_d     = parent;
					state_d   = S_UP_RD;
				end
			end
			S_FETCH: begin
				mem_raddr_a = '0;
				mem_raddr_b = ADDR_W'(count_q - 1'b1);
				state_d     = S_TAKE;
			end
			S_TAKE: begin
				key_d   = mem_rdata_a;
				state_d = S_DONE_CODE;
				if (is_pop_q) begin
					count_d = count_q - 1'b1;
					hold_d  = mem_rdata_b;
					idx_d   = '0;
					if (count_q != CNT_W'(1)) begin
						state_d = S_DN_RD;
					end
				end
			end
			S_DN_RD: begin
				mem_raddr_a = lc_ok ? lc[ADDR_W-1:0] : '0;
				mem_raddr_b = rc_ok ? rc[ADDR_W-1:0] : '0;
				state_d     = S_DN_CMP;
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				priority if (take_r) begin
					mem_wdata = mem_rdata_b;
					idx_d     = rc[ADDR_W-1:0];
					state_d   = S_DN_RD;
				end else if (take_l) begin
					mem_wdata = mem_rdata_a;
					idx_d     = lc[ADDR_W-1:0];
					state_d   = S_DN_RD;
				end else begin
					state_d = S_DONE_CODE;
				end
			end
			S_DONE_CODE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		hold_q   <= hold_d;
		key_q    <= key_d;
		status_q <= status_d;
		is_pop_q <= is_pop_d;
	end

endmodule

FILE: rtl/core/min_heap_priority_queue.sv
// Binary min-heap priority queue over a two-read, one-write key store; reset clears the
// sequencer and the entry count, never the key store.
// A push climbs one level per read and compare pass while its parent is larger; a pop fetches the
// root and the last key, then sinks one level per pass; peek and a pop of the last key move nothing;
// a refused command or the unused opcode goes straight to the response. One transaction at a time,
// the next taken the cycle after the response goes to the output register.
module min_heap_priority_queue #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	mhpq_cmd_if.sink    cmd,
	mhpq_rsp_if.source  rsp
);
	import mhpq_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	// Sequencer to store connections.
	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr, mem_raddr_a, mem_raddr_b;
	logic signed [KEY_WIDTH-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

	// Finished transaction offered by the sequencer.
	logic                        res_valid, res_take;
	logic signed [KEY_WIDTH-1:0] res_key;
	status_t                     res_status;
	logic [CNT_W-1:0]            res_count;

	// Output register, which lets the sequencer start the next command while the
	// previous response is still waiting for the sink.
	logic                        out_valid_q;
	logic signed [KEY_WIDTH-1:0] out_key_q;
	logic [1:0]                  out_status_q;
	logic [CNT_W-1:0]            out_count_q;

	mhpq_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_WIDTH)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	mhpq_ctrl #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd.valid),
		.cmd_ready   (cmd.ready),
		.cmd_opcode  (cmd.opcode),
		.cmd_key     (cmd.key_in),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res_key     (res_key),
		.res_status  (res_status),
		.res_count   (res_count),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b)
	);

	// The output register takes a result whenever it is empty or being drained.
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_key_q    <= res_key;
			out_status_q <= res_status;
			out_count_q  <= res_count;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.key_out     = out_key_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;

	`include "min_heap_priority_queue_assert.svh"

	// A full-heap rejection can only be reported with every slot occupied.
	`MHPQ_ASSERT_SAME(a_full_at_capacity, clk, arst_n, rsp.valid && rsp.status == ST_FULL, rsp.entry_count == CNT_W'(CAPACITY))
	// An empty-heap report carries a zero count and a zero key.
	`MHPQ_ASSERT_SAME(a_empty_is_zero, clk, arst_n, rsp.valid && rsp.status == ST_EMPTY, rsp.entry_count == '0 && rsp.key_out == '0)
	// The entry count never exceeds the store depth.
	`MHPQ_ASSERT_SAME(a_count_bound, clk, arst_n, rsp.valid, rsp.entry_count <= CNT_W'(CAPACITY))
	// In the cycle after a command transaction the sequencer is busy.
	`MHPQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready)

endmodule
